// ===== rtl/bounded_priority_message_queue_unit_defines.svh =====
// Assertion macros shared by the message queue RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef BOUNDED_PRIORITY_MESSAGE_QUEUE_UNIT_DEFINES_SVH
`define BOUNDED_PRIORITY_MESSAGE_QUEUE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define BPMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BPMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpmq_pkg.sv =====
// Types, constants and helper functions for the message queue.
// No dependencies; used by bpmq_cell and the top level.
`default_nettype none

package bpmq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int MESSAGE_BYTES = 8;
  localparam int PRIORITY_BITS = 8;

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MMSG_W = 5;
  localparam int CMP_W  = (CNT_W > MMSG_W) ? CNT_W : MMSG_W;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_RECV = 1'b1;

  localparam logic [1:0] CFG_MAX_MESSAGES  = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_PRIORITY_MODE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0]        payload;
    logic [PRIORITY_BITS-1:0] prio;
    logic [LEN_W-1:0]         len;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic                     pmode;
    logic [PRIORITY_BITS-1:0] prio;
  } cell_ctrl_t;

  function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                              input logic [LEN_W-1:0] b);
    min_len = (a < b) ? a : b;
  endfunction

  // Ones in the low n bytes.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (LEN_W'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    byte_mask = m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bpmq_cell.sv =====
// One queue slot: holds an entry and shifts toward head or tail.
// Depends on bpmq_pkg.
`default_nettype none

module bpmq_cell
  import bpmq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     new_entry,
  input  wire entry_t     left_entry,
  input  wire entry_t     right_entry,
  input  wire logic       occupied,
  input  wire logic       found_in,
  output logic            found_out,
  output entry_t          entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   hit;

  // Insert point: first free slot, or in priority mode the first higher number.
  assign hit       = !occupied || (ctrl.pmode && (entry_r.prio > ctrl.prio));
  assign found_out = found_in || hit;
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (found_in) begin
        entry_nxt = left_entry;
      end else if (hit) begin
        entry_nxt = new_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_priority_message_queue_unit.sv =====
// Bounded message queue with FIFO or stable priority order.
// Depends on bpmq_pkg, bpmq_cell and the assertion macro header.
//
// Usage: one input channel (in_valid/in_ready) carries commands. kind send
// stores a message (payload clipped to max_length bytes); kind receive pops
// the head entry and returns a copy cut to receive_capacity, unused bytes
// zero. Every command yields exactly one result on out_valid/out_ready with
// a status: ok, full (send) or empty (receive).
// The result is registered and shows in the cycle after the input transfer.
// Throughput: one command per cycle while the receiver keeps up; a row of
// QUEUE_DEPTH cells inserts or pops at once via a ripple-found insert point.
// The result sits in an output register; a new command is taken in the same
// cycle the waiting result transfers. While the receiver stalls, in_ready
// stays low and queue contents hold.
// Reset empties the queue (fill count zero) and loads max_messages 16,
// max_length 8, FIFO mode. Slot contents are not cleared; only held entries
// are ever read. Write configuration while idle; it affects later sends.
`default_nettype none
`include "bounded_priority_message_queue_unit_defines.svh"

module bounded_priority_message_queue_unit
  import bpmq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_kind,
  input  wire logic [7:0]               in_msg_priority,
  input  wire logic [DATA_W-1:0]        in_payload,
  input  wire logic [LEN_W-1:0]         in_payload_length,
  input  wire logic [LEN_W-1:0]         in_receive_capacity,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_status,
  output logic [DATA_W-1:0]             out_data,
  output logic [LEN_W-1:0]              out_stored_length,
  output logic [LEN_W-1:0]              out_copied_length,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [MMSG_W-1:0]        cfg_wdata
);

  // Configuration registers
  logic [MMSG_W-1:0] max_messages_r;
  logic [LEN_W-1:0]  max_length_r;
  logic              pmode_r;

  // Queue control
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;

  // Result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           status_r;
  status_t           status_nxt;
  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [LEN_W-1:0]  stored_r;
  logic [LEN_W-1:0]  stored_nxt;
  logic [LEN_W-1:0]  copied_r;
  logic [LEN_W-1:0]  copied_nxt;

  logic              in_xfer;
  logic              is_full;
  logic              is_empty;
  logic              do_push;
  logic              do_pop;
  logic [LEN_W-1:0]  clip_len;
  logic [LEN_W-1:0]  head_copy;
  cell_ctrl_t        ctrl;
  entry_t            new_entry;

  entry_t            cell_q   [QUEUE_DEPTH];
  logic              found    [QUEUE_DEPTH+1];

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign is_full  = (CMP_W'(fill_r) >= CMP_W'(max_messages_r)) ||
                    (fill_r >= CNT_W'(QUEUE_DEPTH));
  assign is_empty = (fill_r == '0);

  assign do_push = in_xfer && (in_kind == KIND_SEND) && !is_full;
  assign do_pop  = in_xfer && (in_kind == KIND_RECV) && !is_empty;

  // Clip to the configured limit and the slot size, drop the excess bytes.
  assign clip_len = min_len(min_len(in_payload_length, max_length_r),
                            LEN_W'(MESSAGE_BYTES));

  always_comb begin
    new_entry.payload = in_payload & byte_mask(clip_len);
    new_entry.prio    = PRIORITY_BITS'(in_msg_priority);
    new_entry.len     = clip_len;
  end

  always_comb begin
    ctrl.push  = do_push;
    ctrl.pop   = do_pop;
    ctrl.pmode = pmode_r;
    ctrl.prio  = new_entry.prio;
  end

  // Cell row: head at index 0. The found chain marks every cell past
  // the insert point; those take their left neighbor on a push.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   occ;

    assign occ = (CNT_W'(i) < fill_r);

    if (i == 0) begin : g_head
      assign left_e = new_entry;
    end else begin : g_body
      assign left_e = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    bpmq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .occupied    (occ),
      .found_in    (found[i]),
      .found_out   (found[i+1]),
      .entry       (cell_q[i])
    );
  end

  // Advance the fill count on a successful push or pop.
  always_comb begin
    fill_nxt = fill_r;
    if (do_push) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  assign head_copy = min_len(min_len(cell_q[0].len, in_receive_capacity),
                             LEN_W'(MESSAGE_BYTES));

  // Build the result; hold it while the receiver stalls.
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    stored_nxt    = stored_r;
    copied_nxt    = copied_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      data_nxt      = '0;
      stored_nxt    = '0;
      copied_nxt    = '0;
      if (in_kind == KIND_SEND) begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end
      end else if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        data_nxt   = cell_q[0].payload & byte_mask(head_copy);
        stored_nxt = cell_q[0].len;
        copied_nxt = head_copy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r         <= '0;
      out_valid_r    <= 1'b0;
      max_messages_r <= MMSG_W'(16);
      max_length_r   <= LEN_W'(8);
      pmode_r        <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_MESSAGES:  max_messages_r <= cfg_wdata;
          CFG_MAX_LENGTH:    max_length_r   <= cfg_wdata[LEN_W-1:0];
          CFG_PRIORITY_MODE: pmode_r        <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
    stored_r <= stored_nxt;
    copied_r <= copied_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_data          = data_r;
  assign out_stored_length = stored_r;
  assign out_copied_length = copied_r;

  `BPMQ_ASSERT(a_fill_bound, fill_r <= CNT_W'(QUEUE_DEPTH), "fill count above depth")
  `BPMQ_ASSERT_NEXT(a_push_count, do_push, fill_r == $past(fill_r) + CNT_W'(1), "push lost")
  `BPMQ_ASSERT_NEXT(a_pop_count, do_pop, fill_r == $past(fill_r) - CNT_W'(1), "pop lost")
  `BPMQ_ASSERT(a_copy_le_stored, !out_valid_r || (copied_r <= stored_r), "copy exceeds stored")
  `BPMQ_ASSERT(a_fail_zero, !out_valid_r || (status_r == ST_OK) || ((data_r == '0) && (stored_r == '0)), "failed result not zero")

endmodule

`default_nettype wire

// ===== test/queue_scoreboard_pkg.sv =====
// Scoreboard for the bounded message queue: a predictor of the queue and
// the list of replies it still waits for. Depends on bpmq_pkg.
package queue_scoreboard_pkg;
  import bpmq_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  stored_len;
    logic [LEN_W-1:0]  copied_len;
  } reply_t;

  class queue_reply_scoreboard;
    logic [DATA_W-1:0]        slot_bytes [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] slot_prio  [QUEUE_DEPTH];
    int                       slot_len   [QUEUE_DEPTH];
    int                       held;
    int                       limit_msgs;
    int                       keep_bytes;
    bit                       by_priority;
    reply_t                   pending_replies [$];
    int sent_ok, refused_full, delivered, found_empty, compared, mismatches;

    function new();
      held = 0;
      limit_msgs = 16;
      keep_bytes = 8;
      by_priority = 1'b0;
      sent_ok = 0;
      refused_full = 0;
      delivered = 0;
      found_empty = 0;
      compared = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [MMSG_W-1:0] value);
      case (index)
        CFG_MAX_MESSAGES:  limit_msgs = int'(value);
        CFG_MAX_LENGTH:    keep_bytes = int'(value[3:0]);
        CFG_PRIORITY_MODE: by_priority = value[0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] low_bytes_mask(int n);
      if (n >= MESSAGE_BYTES) return '1;
      return (DATA_W'(1) << (8 * n)) - DATA_W'(1);
    endfunction

    // Advance the queue copy by one command and return the reply it causes.
    function reply_t predict_reply(logic kind, logic [7:0] prio_in,
                                   logic [DATA_W-1:0] msg_bytes,
                                   logic [LEN_W-1:0] plen, logic [LEN_W-1:0] cap);
      reply_t                   r;
      int                       pos;
      int                       keep;
      int                       i;
      logic [PRIORITY_BITS-1:0] prio;
      r = '0;
      r.status = ST_OK;
      prio = prio_in[PRIORITY_BITS-1:0];
      if (kind == KIND_SEND) begin
        if (held >= limit_msgs || held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          refused_full++;
        end else begin
          keep = int'(plen);
          if (keep > keep_bytes) keep = keep_bytes;
          if (keep > MESSAGE_BYTES) keep = MESSAGE_BYTES;
          pos = held;
          if (by_priority) begin
            pos = 0;
            while (pos < held && slot_prio[pos] <= prio) pos++;
          end
          for (i = held; i > pos; i--) begin
            slot_bytes[i] = slot_bytes[i-1];
            slot_prio[i]  = slot_prio[i-1];
            slot_len[i]   = slot_len[i-1];
          end
          slot_bytes[pos] = msg_bytes & low_bytes_mask(keep);
          slot_prio[pos]  = prio;
          slot_len[pos]   = keep;
          held++;
          sent_ok++;
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          found_empty++;
        end else begin
          keep = (int'(cap) < slot_len[0]) ? int'(cap) : slot_len[0];
          if (keep > MESSAGE_BYTES) keep = MESSAGE_BYTES;
          r.stored_len = LEN_W'(slot_len[0]);
          r.copied_len = LEN_W'(keep);
          r.data = slot_bytes[0] & low_bytes_mask(keep);
          for (i = 1; i < held; i++) begin
            slot_bytes[i-1] = slot_bytes[i];
            slot_prio[i-1]  = slot_prio[i];
            slot_len[i-1]   = slot_len[i];
          end
          held--;
          delivered++;
        end
      end
      return r;
    endfunction

    function void note_command(logic kind, logic [7:0] prio, logic [DATA_W-1:0] msg_bytes,
                               logic [LEN_W-1:0] plen, logic [LEN_W-1:0] cap);
      pending_replies.push_back(predict_reply(kind, prio, msg_bytes, plen, cap));
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected reply: status %0d data %h stored %0d copied %0d",
                   got.status, got.data, got.stored_len, got.copied_len);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      compared++;
      if (got.status !== want.status || got.data !== want.data ||
          got.stored_len !== want.stored_len || got.copied_len !== want.copied_len) begin
        if (mismatches < 10) begin
          $display("reply %0d mismatch: expected status %0d data %h stored %0d copied %0d",
                   compared, want.status, want.data, want.stored_len, want.copied_len);
          $display("  actual status %0d data %h stored %0d copied %0d",
                   got.status, got.data, got.stored_len, got.copied_len);
        end
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench of the bounded message queue: clock, reset, drivers
// and monitor. Depends on bpmq_pkg, queue_scoreboard_pkg and the queue RTL.
module tb_top;
  import bpmq_pkg::*;
  import queue_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 120;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [7:0]        in_msg_priority;
  logic [DATA_W-1:0] in_payload;
  logic [LEN_W-1:0]  in_payload_length;
  logic [LEN_W-1:0]  in_receive_capacity;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_data;
  logic [LEN_W-1:0]  out_stored_length;
  logic [LEN_W-1:0]  out_copied_length;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [MMSG_W-1:0] cfg_wdata;

  queue_reply_scoreboard sb;
  reply_t                seen;
  bit                    quiet_phase;   // both sides run without gaps
  int                    settings_used;
  int                    cycle_count;

  bounded_priority_message_queue_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_msg_priority     (in_msg_priority),
    .in_payload          (in_payload),
    .in_payload_length   (in_payload_length),
    .in_receive_capacity (in_receive_capacity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_data            (out_data),
    .out_stored_length   (out_stored_length),
    .out_copied_length   (out_copied_length),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost reply ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Sample both channels at the rising edge. Note the command transfer before
  // checking the reply so that ordering holds even if both transfer at once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_command(in_kind, in_msg_priority, in_payload,
                        in_payload_length, in_receive_capacity);
      if (out_valid && out_ready) begin
        seen.status     = status_t'(out_status);
        seen.data       = out_data;
        seen.stored_len = out_stored_length;
        seen.copied_len = out_copied_length;
        sb.check_reply(seen);
      end
    end
  end

  // Result side: outside quiet phases, stall a random number of cycles before
  // taking each reply; hold ready high until the transfer happens.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Present one command. Called at a falling edge; returns at the falling
  // edge after the transfer with valid still high, so back-to-back commands
  // keep valid up without a dip.
  task automatic push_command(logic kind, logic [7:0] prio, logic [DATA_W-1:0] msg_bytes,
                              logic [LEN_W-1:0] plen, logic [LEN_W-1:0] cap);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            = 1'b1;
    in_kind             = kind;
    in_msg_priority     = prio;
    in_payload          = msg_bytes;
    in_payload_length   = plen;
    in_receive_capacity = cap;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding reply and let the output register
  // drain, so the block is idle for a register write.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [MMSG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    sb.set_register(index, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(int lim, int keep, bit mode);
    settle();
    write_register(CFG_MAX_MESSAGES, MMSG_W'(lim));
    write_register(CFG_MAX_LENGTH, MMSG_W'(keep));
    write_register(CFG_PRIORITY_MODE, MMSG_W'(mode));
    settings_used++;
  endtask

  initial begin
    int              lim;
    int              keep;
    bit              mode;
    int              send_pct;
    int              prio_span;
    logic            kind;
    logic [DATA_W-1:0] msg_bytes;

    sb                  = new();
    settings_used       = 1;
    quiet_phase         = 1'b0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = KIND_SEND;
    in_msg_priority     = '0;
    in_payload          = '0;
    in_payload_length   = '0;
    in_receive_capacity = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_MAX_MESSAGES;
    cfg_wdata           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset setting: empty receive, both payload extremes, a cut copy.
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);
    push_command(KIND_SEND, 8'd255, '1, 4'd8, 4'd0);
    push_command(KIND_SEND, 8'd0, 64'h0123_4567_89ab_cdef, 4'd3, 4'd0);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd2);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd0);

    // Zero limit refuses every send; zero length on top.
    apply_setting(0, 0, 1'b0);
    push_command(KIND_SEND, 8'd9, '1, 4'd8, 4'd8);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);

    // Priority order with a limit of two and empty messages.
    apply_setting(2, 0, 1'b1);
    push_command(KIND_SEND, 8'd5, '1, 4'd8, 4'd0);
    push_command(KIND_SEND, 8'd3, 64'h55aa_55aa_55aa_55aa, 4'd8, 4'd0);
    push_command(KIND_SEND, 8'd1, '1, 4'd8, 4'd0);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);

    // Limit above depth, length above message size, equal priorities.
    apply_setting(31, 15, 1'b1);
    push_command(KIND_SEND, 8'd7, 64'h1111_2222_3333_4444, 4'd8, 4'd0);
    push_command(KIND_SEND, 8'd7, 64'h5555_6666_7777_8888, 4'd5, 4'd0);
    push_command(KIND_SEND, 8'd2, 64'h9999_aaaa_bbbb_cccc, 4'd8, 4'd0);
    push_command(KIND_SEND, 8'd200, '1, 4'd0, 4'd0);

    // Lower the limit below the fill and go back to FIFO: held order stays.
    apply_setting(1, 1, 1'b0);
    push_command(KIND_SEND, 8'd0, '1, 4'd8, 4'd0);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd3);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);
    push_command(KIND_SEND, 8'd0, '1, 4'd8, 4'd0);
    push_command(KIND_RECV, 8'd0, '0, 4'd0, 4'd8);

    // Random phases: a fresh setting each, the queue content carried over.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin lim = 16; keep = 8;  mode = 1'b1; end
        1: begin lim = 31; keep = 15; mode = 1'b0; end
        2: begin lim = 1;  keep = 0;  mode = 1'b1; end
        default: begin
          case ($urandom_range(0, 9))
            0: lim = 0;
            1: lim = 1;
            2: lim = 16;
            3: lim = 31;
            4: lim = 17;
            default: lim = $urandom_range(1, 16);
          endcase
          case ($urandom_range(0, 7))
            0: keep = 0;
            1: keep = 8;
            2: keep = 15;
            default: keep = $urandom_range(1, 8);
          endcase
          mode = 1'($urandom_range(0, 1));
        end
      endcase
      apply_setting(lim, keep, mode);
      quiet_phase = (phase % 4 == 3);
      case ($urandom_range(0, 2))
        0: send_pct = 30;
        1: send_pct = 50;
        default: send_pct = 70;
      endcase
      // A narrow priority span piles up ties to exercise stable order.
      prio_span = $urandom_range(0, 1) ? 3 : 255;
      repeat (PHASE_ITEMS) begin
        kind = ($urandom_range(0, 99) < send_pct) ? KIND_SEND : KIND_RECV;
        case ($urandom_range(0, 9))
          0: msg_bytes = '1;
          1: msg_bytes = '0;
          default: msg_bytes = {$urandom, $urandom};
        endcase
        push_command(kind, 8'($urandom_range(0, prio_span)), msg_bytes,
                     LEN_W'($urandom_range(0, 8)), LEN_W'($urandom_range(0, 8)));
      end
    end
    quiet_phase = 1'b0;
    settle();

    $display("queue run: %0d sends stored, %0d refused full, %0d receives delivered, %0d empty",
             sb.sent_ok, sb.refused_full, sb.delivered, sb.found_empty);
    $display("%0d replies compared over %0d register settings, %0d mismatches",
             sb.compared, settings_used, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bpmq_pkg.sv
rtl/bpmq_cell.sv
rtl/bounded_priority_message_queue_unit.sv
test/queue_scoreboard_pkg.sv
test/tb_top.sv
